### rtl/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg: shared types and constants of the alignment score block
// Transaction payloads, coefficient set, the wave record that moves along the
// cell chain, register indexes and the score saturation helper.
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int unsigned SCORE_W = 20;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned COEF_W  = 8;
  localparam int unsigned ADDR_W  = 4;

  localparam int SCORE_HI = (1 <<< (SCORE_W - 1)) - 1;
  localparam int SCORE_LO = -(1 <<< (SCORE_W - 1));

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  // Commands of an input transaction.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_STREAM = 1'b1;

  // Register indexes (word address bits).
  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    score_t score;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    coef_t match;
    coef_t mismatch;
    coef_t gap;
  } coef_set_t;

  // One row update travelling along the chain. diag is the previous-row value
  // of the cell to the left, left is its new value.
  typedef struct packed {
    logic             valid;
    logic             init;
    logic             update;
    logic [SYM_W-1:0] symbol;
    score_t           diag;
    score_t           left;
  } wave_t;

  function automatic score_t sat_score(input logic signed [31:0] v);
    score_t r;
    if (v > SCORE_HI) begin
      r = score_t'(SCORE_HI);
    end else if (v < SCORE_LO) begin
      r = score_t'(SCORE_LO);
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/gas_cell.sv
// ----------------------------------------------------------------------------
// gas_cell: one column of the score row
// Holds one first-sequence symbol and its score, updates the score as a row
// wave passes and hands the wave on, registered, to the next column in the next cycle.
// ----------------------------------------------------------------------------
module gas_cell #(
  parameter int unsigned LEN_W = 9,
  parameter int unsigned INDEX = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gas_pkg::coef_set_t         coef_i,
  input  logic [LEN_W-1:0]           len_i,
  input  logic                       wr_en_i,
  input  logic [LEN_W-1:0]           wr_idx_i,
  input  logic [gas_pkg::SYM_W-1:0]  wr_sym_i,
  input  gas_pkg::wave_t             wave_i,
  output gas_pkg::wave_t             wave_o
);

  localparam int unsigned SW = gas_pkg::SCORE_W;

  logic [gas_pkg::SYM_W-1:0] sym_q;
  gas_pkg::score_t           val_q, val_d;
  logic                      val_we;
  gas_pkg::wave_t            wave_q, wave_d;

  logic                      active;
  gas_pkg::coef_t            sub;
  gas_pkg::score_t           up;
  gas_pkg::score_t           cell_val;
  logic signed [SW:0]        t_bord, t_diag, t_up, t_left, best;

  // Columns beyond the loaded length only pass the wave through.
  assign active = (LEN_W'(INDEX) <= len_i);
  assign sub    = (sym_q == wave_i.symbol) ? coef_i.match : coef_i.mismatch;

  always_comb begin
    t_bord = (SW+1)'(wave_i.diag) + (SW+1)'(coef_i.gap);
    // On the first row the stored value is replaced by the border value.
    up     = wave_i.init ? gas_pkg::sat_score(32'(t_bord)) : val_q;
    t_diag = (SW+1)'(wave_i.diag) + (SW+1)'(sub);
    t_up   = (SW+1)'(up) + (SW+1)'(coef_i.gap);
    t_left = (SW+1)'(wave_i.left) + (SW+1)'(coef_i.gap);
    best   = t_diag;
    if (t_up > best) begin
      best = t_up;
    end
    if (t_left > best) begin
      best = t_left;
    end
    cell_val = gas_pkg::sat_score(32'(best));
  end

  always_comb begin
    wave_d = wave_i;
    val_d  = cell_val;
    val_we = wave_i.valid && wave_i.update && active;
    if (active) begin
      if (wave_i.update) begin
        wave_d.left = cell_val;
        wave_d.diag = up;
      end else begin
        wave_d.left = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_q <= val_d;
    end
    if (wr_en_i && (wr_idx_i == LEN_W'(INDEX - 1))) begin
      sym_q <= wr_sym_i;
    end
  end

  assign wave_o = wave_q;

endmodule

### rtl/global_alignment_score.sv
// ----------------------------------------------------------------------------
// global_alignment_score: global alignment score with linear gap cost
// A chain of MAX_LEN cells holds the first sequence and one row of scores.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions carry a command, a symbol byte and a last flag. A load
// command stores one first-sequence symbol in the cell chain. A stream command
// launches a row wave from the column-zero border logic; the wave crosses one
// cell per cycle, so in_ready_o returns once it has left the last cell and,
// after one marked last, once its result has left the holding register.
// The wave length is set by the number of cells in the chain.
// A stream transaction marked last produces one result transaction (score
// and overflow flag), which goes to the holding register and then to the
// output register when that is free. The result waits in the output register
// while the next items are taken; a second result waits in the holding
// register, and input is held off while a row is in flight or that register
// is full. Match, mismatch and gap scores are written over the APB port; the
// user must write them only while the block is idle, and the block itself
// has no check for it. Reset restores the default scores and clears lengths,
// row count and flags; the stored symbols and scores are not cleared and are
// only read after being written.
// ----------------------------------------------------------------------------
module global_alignment_score #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gas_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gas_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gas_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  gas_pkg::coef_set_t  coef_q, coef_d;
  logic [LEN_W-1:0]    first_len_q, first_len_d;
  logic                first_over_q, first_over_d;
  logic                load_done_q, load_done_d;
  logic [LEN_W-1:0]    row_idx_q, row_idx_d;
  logic                ovf_seen_q, ovf_seen_d;
  logic                busy_q, busy_d;
  logic                job_last_q, job_last_d;
  logic                job_ovf_q, job_ovf_d;
  gas_pkg::score_t     col0_q, col0_d;
  gas_pkg::wave_t      wave0_q, wave0_d;
  logic                hold_valid_q, hold_valid_d;
  gas_pkg::out_item_t  hold_q, hold_d;
  logic                out_valid_q, out_valid_d;
  gas_pkg::out_item_t  out_q, out_d;

  gas_pkg::wave_t      chain [0:MAX_LEN];

  logic                accept;
  logic                wr_en;
  logic [LEN_W-1:0]    wr_idx;
  logic                row_init, row_upd;
  logic [LEN_W-1:0]    row_p1;
  logic signed [31:0]  border_prod;
  gas_pkg::score_t     col0_new;
  logic                ovf_now;
  logic                apb_wr;

  assign in_ready_o = !busy_q && !hold_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  // Column-zero border for the next row: (row + 1) * gap, saturated.
  assign row_init    = (row_idx_q == '0);
  assign row_upd     = (row_idx_q < LEN_W'(MAX_LEN));
  assign row_p1      = row_idx_q + LEN_W'(1);
  assign border_prod = $signed(32'(row_p1)) * 32'(coef_q.gap);
  assign col0_new    = gas_pkg::sat_score(border_prod);
  assign ovf_now     = (row_init ? first_over_q : ovf_seen_q) | !row_upd;

  assign wr_idx = load_done_q ? '0 : first_len_q;
  assign wr_en  = accept && (in_data_i.command == gas_pkg::CMD_LOAD) &&
                  (load_done_q || (first_len_q < LEN_W'(MAX_LEN)));

  always_comb begin
    first_len_d  = first_len_q;
    first_over_d = first_over_q;
    load_done_d  = load_done_q;
    row_idx_d    = row_idx_q;
    ovf_seen_d   = ovf_seen_q;
    busy_d       = busy_q;
    job_last_d   = job_last_q;
    job_ovf_d    = job_ovf_q;
    col0_d       = col0_q;
    wave0_d      = wave0_q;
    wave0_d.valid = 1'b0;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (hold_valid_q && (!out_valid_q || out_ready_i)) begin
      out_d        = hold_q;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d  = 1'b0;
    end

    if (accept) begin
      if (in_data_i.command == gas_pkg::CMD_LOAD) begin
        if (load_done_q) begin
          first_len_d  = LEN_W'(1);
          first_over_d = 1'b0;
        end else if (first_len_q < LEN_W'(MAX_LEN)) begin
          first_len_d  = first_len_q + LEN_W'(1);
        end else begin
          first_over_d = 1'b1;
        end
        load_done_d = in_data_i.last;
        row_idx_d   = '0;
      end else begin
        wave0_d.valid  = 1'b1;
        wave0_d.init   = row_init;
        wave0_d.update = row_upd;
        wave0_d.symbol = in_data_i.symbol;
        wave0_d.diag   = row_init ? '0 : col0_q;
        wave0_d.left   = row_upd ? col0_new : col0_q;
        if (row_upd) begin
          col0_d = col0_new;
        end
        ovf_seen_d = ovf_now;
        job_ovf_d  = ovf_now;
        job_last_d = in_data_i.last;
        busy_d     = 1'b1;
        if (in_data_i.last) begin
          row_idx_d = '0;
        end else if (row_upd) begin
          row_idx_d = row_p1;
        end
      end
    end

    // The wave leaving the last cell carries the bottom-right score.
    if (chain[MAX_LEN].valid) begin
      busy_d = 1'b0;
      if (job_last_q) begin
        hold_valid_d    = 1'b1;
        hold_d.score    = chain[MAX_LEN].left;
        hold_d.overflow = job_ovf_q;
      end
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_comb begin
    coef_d = coef_q;
    if (apb_wr) begin
      case (paddr[3:2])
        gas_pkg::REG_MATCH:    coef_d.match    = pwdata[gas_pkg::COEF_W-1:0];
        gas_pkg::REG_MISMATCH: coef_d.mismatch = pwdata[gas_pkg::COEF_W-1:0];
        gas_pkg::REG_GAP:      coef_d.gap      = pwdata[gas_pkg::COEF_W-1:0];
        default:               coef_d          = coef_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gas_pkg::REG_MATCH:    prdata = 32'(coef_q.match);
      gas_pkg::REG_MISMATCH: prdata = 32'(coef_q.mismatch);
      gas_pkg::REG_GAP:      prdata = 32'(coef_q.gap);
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.match    <= gas_pkg::COEF_W'(1);
      coef_q.mismatch <= gas_pkg::COEF_W'(-1);
      coef_q.gap      <= gas_pkg::COEF_W'(-2);
      first_len_q     <= '0;
      first_over_q    <= 1'b0;
      load_done_q     <= 1'b0;
      row_idx_q       <= '0;
      ovf_seen_q      <= 1'b0;
      busy_q          <= 1'b0;
      wave0_q         <= '0;
      hold_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      coef_q          <= coef_d;
      first_len_q     <= first_len_d;
      first_over_q    <= first_over_d;
      load_done_q     <= load_done_d;
      row_idx_q       <= row_idx_d;
      ovf_seen_q      <= ovf_seen_d;
      busy_q          <= busy_d;
      wave0_q         <= wave0_d;
      hold_valid_q    <= hold_valid_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_last_q     <= job_last_d;
    job_ovf_q      <= job_ovf_d;
    col0_q         <= col0_d;
    hold_q         <= hold_d;
    out_q          <= out_d;
  end

  assign chain[0] = wave0_q;

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    gas_cell #(
      .LEN_W (LEN_W),
      .INDEX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .coef_i   (coef_q),
      .len_i    (first_len_q),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_sym_i (in_data_i.symbol),
      .wave_i   (chain[k-1]),
      .wave_o   (chain[k])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/gas_score_checker.sv
// ----------------------------------------------------------------------------
// gas_score_checker: scoreboard of the global alignment score block
// Watches the input, result and register channels, keeps its own copy of the
// first sequence and the score row, works out the score of every alignment
// and compares each result transaction with the oldest score expected.
// ----------------------------------------------------------------------------
module gas_score_checker #(
  parameter int MAX_LEN = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  gas_pkg::in_item_t          in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  gas_pkg::out_item_t         out_data_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [gas_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output int                         err_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  int                        match_c;
  int                        mismatch_c;
  int                        gap_c;
  logic [gas_pkg::SYM_W-1:0] first_seq [MAX_LEN];
  int                        first_len;
  int                        rows_done;
  logic                      first_trunc;
  logic                      seq_closed;
  logic                      trunc_seen;
  longint                    score_row [MAX_LEN+1];
  gas_pkg::out_item_t        expected_scores [$];

  function automatic longint clamp_score(input longint v);
    if (v > gas_pkg::SCORE_HI) return gas_pkg::SCORE_HI;
    if (v < gas_pkg::SCORE_LO) return gas_pkg::SCORE_LO;
    return v;
  endfunction

  // Applies one accepted input transaction to the mirrored state and queues
  // the score when the transaction closes an alignment.
  function automatic void align_step(input gas_pkg::in_item_t it);
    longint             diag_v;
    longint             up_v;
    longint             cell_v;
    int                 j;
    gas_pkg::out_item_t want;
    if (it.command == gas_pkg::CMD_LOAD) begin
      if (seq_closed) begin
        first_len   = 0;
        first_trunc = 1'b0;
        seq_closed  = 1'b0;
      end
      rows_done = 0;
      if (first_len < MAX_LEN) begin
        first_seq[first_len] = it.symbol;
        first_len++;
      end else begin
        first_trunc = 1'b1;
      end
      if (it.last) seq_closed = 1'b1;
      return;
    end
    if (rows_done == 0) begin
      for (j = 0; j <= first_len; j++) score_row[j] = clamp_score(longint'(j) * gap_c);
      trunc_seen = first_trunc;
    end
    if (rows_done < MAX_LEN) begin
      diag_v = score_row[0];
      score_row[0] = clamp_score(longint'(rows_done + 1) * gap_c);
      for (j = 1; j <= first_len; j++) begin
        up_v = score_row[j];
        cell_v = diag_v + ((first_seq[j-1] == it.symbol) ? match_c : mismatch_c);
        if (up_v + gap_c > cell_v) cell_v = up_v + gap_c;
        if (score_row[j-1] + gap_c > cell_v) cell_v = score_row[j-1] + gap_c;
        diag_v = up_v;
        score_row[j] = clamp_score(cell_v);
      end
      rows_done++;
    end else begin
      // Second-sequence symbols past the row limit are dropped.
      trunc_seen = 1'b1;
    end
    if (it.last) begin
      want.score    = gas_pkg::score_t'(score_row[first_len]);
      want.overflow = trunc_seen;
      expected_scores.push_back(want);
      rows_done = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gas_pkg::out_item_t want;
    if (!rst_ni) begin
      match_c     = 1;
      mismatch_c  = -1;
      gap_c       = -2;
      first_len   = 0;
      rows_done   = 0;
      first_trunc = 1'b0;
      seq_closed  = 1'b0;
      trunc_seen  = 1'b0;
      expected_scores.delete();
      err_count_o = 0;
      pending_o   = 0;
      checked_o   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[gas_pkg::ADDR_W-1:2])
          gas_pkg::REG_MATCH:
            match_c    = int'(gas_pkg::coef_t'(pwdata_i[gas_pkg::COEF_W-1:0]));
          gas_pkg::REG_MISMATCH:
            mismatch_c = int'(gas_pkg::coef_t'(pwdata_i[gas_pkg::COEF_W-1:0]));
          gas_pkg::REG_GAP:
            gap_c      = int'(gas_pkg::coef_t'(pwdata_i[gas_pkg::COEF_W-1:0]));
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_scores.size() == 0) begin
          err_count_o++;
          $display("%0t: result with none expected: expected nothing, %s %0d overflow %0b",
                   $time, "actual score", $signed(out_data_i.score), out_data_i.overflow);
        end else begin
          want = expected_scores.pop_front();
          checked_o++;
          if (out_data_i.score !== want.score) begin
            err_count_o++;
            $display("%0t: score mismatch: expected %0d, actual %0d",
                     $time, $signed(want.score), $signed(out_data_i.score));
          end
          if (out_data_i.overflow !== want.overflow) begin
            err_count_o++;
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, want.overflow, out_data_i.overflow);
          end
        end
      end
      if (in_valid_i && in_ready_i) align_step(in_data_i);
      pending_o = expected_scores.size();
    end
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the global alignment score block
// Loads first sequences and streams second sequences under several score
// settings, with random idling on both channels, a long result stall and
// oversized sequences; a separate checker predicts and compares every score.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 256;
  localparam int LIMIT        = 2_000_000;
  localparam int DRAIN        = MAX_LEN + 8;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 750;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  gas_pkg::in_item_t          in_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  gas_pkg::out_item_t         out_data_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [gas_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  int err_count;
  int pending;
  int checked;
  int n_loads    = 0;
  int n_streams  = 0;
  int n_settings = 0;
  int cycles     = 0;
  bit steady       = 1'b0;
  bit hold_request = 1'b0;

  global_alignment_score #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  gas_score_checker #(.MAX_LEN(MAX_LEN)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, a steady stretch, and one long hold on request.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic logic [gas_pkg::SYM_W-1:0] pick_symbol(input bit narrow);
    logic [gas_pkg::SYM_W-1:0] s;
    s = gas_pkg::SYM_W'($urandom_range(255));
    if (narrow) begin
      // A four-letter alphabet gives plenty of matches.
      case ($urandom_range(3))
        0:       s = 8'h00;
        1:       s = 8'hFF;
        2:       s = 8'hA5;
        default: s = 8'h5A;
      endcase
    end
    return s;
  endfunction

  // Called at a rising edge; returns at the edge that accepted the transaction.
  task automatic send_item(input logic cmd, input logic [gas_pkg::SYM_W-1:0] sym,
                           input logic lst);
    gas_pkg::in_item_t it;
    int                gap;
    it.command = cmd;
    it.symbol  = sym;
    it.last    = lst;
    if (!steady) begin
      gap = 0;
      if ($urandom_range(19) == 0) gap = $urandom_range(1, MAX_LEN + 4);
      while (gap > 0 || $urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        if (gap > 0) gap--;
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (cmd == gas_pkg::CMD_LOAD) n_loads++;
    else n_streams++;
  endtask

  task automatic load_seq(input int len, input bit narrow, input bit closed);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(gas_pkg::CMD_LOAD, pick_symbol(narrow), closed && (k == len - 1));
    end
  endtask

  task automatic stream_seq(input int len, input bit narrow, input bit closed);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(gas_pkg::CMD_STREAM, pick_symbol(narrow), closed && (k == len - 1));
    end
  endtask

  // Waits until every score has come back and the block has finished any
  // row that produces no result.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [gas_pkg::COEF_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gas_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= {{(32 - gas_pkg::COEF_W){val[gas_pkg::COEF_W-1]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_scores(input int m, input int mm, input int g);
    settle();
    write_reg(gas_pkg::REG_MATCH, gas_pkg::COEF_W'(m));
    write_reg(gas_pkg::REG_MISMATCH, gas_pkg::COEF_W'(mm));
    write_reg(gas_pkg::REG_GAP, gas_pkg::COEF_W'(g));
    n_settings++;
  endtask

  task automatic random_alignment();
    int kind;
    int reps;
    int k;
    bit narrow;
    kind   = $urandom_range(99);
    narrow = 1'($urandom_range(1));
    if (kind < 70) begin
      load_seq(($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12),
               narrow, 1'b1);
      reps = $urandom_range(1, 3);
      for (k = 0; k < reps; k++) stream_seq($urandom_range(1, 5), narrow, 1'b1);
    end else if (kind < 85) begin
      // Open first sequences, streams cut short by a load, appends after a stream.
      load_seq($urandom_range(1, 8), narrow, 1'($urandom_range(1)));
      stream_seq($urandom_range(1, 4), narrow, 1'($urandom_range(1)));
      load_seq($urandom_range(0, 3), narrow, 1'($urandom_range(1)));
      stream_seq($urandom_range(1, 3), narrow, 1'b1);
    end else begin
      reps = $urandom_range(1, 6);
      for (k = 0; k < reps; k++) begin
        send_item(1'($urandom_range(1)), pick_symbol(narrow), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : stimulus
    int start;
    int phase;
    int k;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_scores(1, -1, -2);

    // Streaming against an empty first sequence.
    send_item(gas_pkg::CMD_STREAM, 8'h00, 1'b0);
    send_item(gas_pkg::CMD_STREAM, 8'hFF, 1'b1);
    // Extreme symbols, one match and one mismatch per row.
    send_item(gas_pkg::CMD_LOAD, 8'h00, 1'b0);
    send_item(gas_pkg::CMD_LOAD, 8'hFF, 1'b1);
    send_item(gas_pkg::CMD_STREAM, 8'hFF, 1'b0);
    send_item(gas_pkg::CMD_STREAM, 8'hFF, 1'b1);
    // A load abandons the stream in progress and starts a new first sequence.
    send_item(gas_pkg::CMD_LOAD, 8'h55, 1'b0);
    send_item(gas_pkg::CMD_LOAD, 8'hAA, 1'b1);
    send_item(gas_pkg::CMD_STREAM, 8'h55, 1'b0);
    send_item(gas_pkg::CMD_LOAD, 8'hAA, 1'b1);
    send_item(gas_pkg::CMD_STREAM, 8'hAA, 1'b1);
    // Streaming before the first sequence is closed, then appending to it.
    send_item(gas_pkg::CMD_LOAD, 8'h0F, 1'b0);
    send_item(gas_pkg::CMD_STREAM, 8'h0F, 1'b1);
    send_item(gas_pkg::CMD_LOAD, 8'hF0, 1'b1);
    send_item(gas_pkg::CMD_STREAM, 8'hF0, 1'b0);
    send_item(gas_pkg::CMD_STREAM, 8'h0F, 1'b1);

    set_scores(127, -128, -128);
    send_item(gas_pkg::CMD_LOAD, 8'h80, 1'b0);
    send_item(gas_pkg::CMD_LOAD, 8'h01, 1'b1);
    send_item(gas_pkg::CMD_STREAM, 8'h80, 1'b1);
    set_scores(-128, 127, 127);
    send_item(gas_pkg::CMD_LOAD, 8'h7F, 1'b1);
    send_item(gas_pkg::CMD_STREAM, 8'h7F, 1'b0);
    send_item(gas_pkg::CMD_STREAM, 8'hFE, 1'b1);

    // The first four phases always run; random alignments top up the count.
    start = n_loads + n_streams;
    phase = 0;
    while (phase < 4 || n_loads + n_streams - start < RANDOM_ITEMS) begin
      case (phase % 8)
        0:       set_scores(127, -128, -128);
        1:       set_scores(-128, 127, 127);
        2:       set_scores(0, 0, 0);
        3:       set_scores(1, -1, -2);
        4:       set_scores(127, 127, -128);
        default: set_scores($urandom_range(255), $urandom_range(255), $urandom_range(255));
      endcase
      steady = (phase == 3);
      case (phase)
        0: begin
          // An oversized second sequence; its closing symbol is itself dropped.
          load_seq(4, 1'b1, 1'b1);
          stream_seq(MAX_LEN + 1, 1'b1, 1'b1);
        end
        1: begin
          // Results are held back long enough for the block to stall its input.
          load_seq(3, 1'b1, 1'b1);
          hold_request = 1'b1;
          for (k = 0; k < 10; k++) stream_seq(1, 1'b1, 1'b1);
        end
        2: begin
          // An oversized first sequence flags every alignment against it.
          load_seq(MAX_LEN + 2, 1'b0, 1'b1);
          stream_seq(3, 1'b0, 1'b1);
          stream_seq(1, 1'b0, 1'b1);
        end
        default: ;
      endcase
      for (k = 0; k < 4; k++) begin
        if (phase < 4 || n_loads + n_streams - start < RANDOM_ITEMS) random_alignment();
      end
      phase++;
    end

    settle();
    $display("Covered %0d input transactions (%0d loads, %0d streams) under %0d score settings.",
             n_loads + n_streams, n_loads, n_streams, n_settings);
    $display("Compared %0d alignment results, including truncated sequences and a long stall.",
             checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
